// ===== rtl/cwg_pkg.sv =====
// Shared types and constants for the crank wheel gap sync decoder.
`default_nettype none

package cwg_pkg;

  localparam int STAMP_BITS = 32;

  localparam logic [STAMP_BITS-1:0] NO_HISTORY_TARGET = STAMP_BITS'(100000000);
  localparam logic [3:0]            SYNC_TOOTH        = 4'd12;
  localparam logic [2:0]            LIMIT_FOUR        = 3'd5;
  localparam logic [2:0]            LIMIT_SIX         = 3'd7;
  localparam logic [15:0]           INIT_FILTER_RESET = 16'd50;

  typedef enum logic [1:0] {
    REG_WHEEL       = 2'd0,
    REG_FILTER      = 2'd1,
    REG_INIT_FILTER = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    FILT_NONE    = 2'd0,
    FILT_QUARTER = 2'd1,
    FILT_HALF    = 2'd2,
    FILT_THREEQ  = 2'd3
  } filter_level_t;

  typedef struct packed {
    logic        accepted;
    logic        long_gap_seen;
    logic        sync_lost_now;
    logic        in_sync;
    logic [2:0]  virtual_tooth;
    logic        virtual_tooth_event;
    logic        cycle_start;
    logic        second_revolution;
    logic [7:0]  sync_loss_total;
    logic [31:0] revolution_total;
    logic [31:0] cycle_period;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/cwg_core.sv =====
// Tooth gap filter, long gap detection and virtual tooth tracking state.
`default_nettype none

module cwg_core
  import cwg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  input  wire logic                  step,
  input  wire logic [STAMP_BITS-1:0] edge_time,
  output result_t                    res
);

  logic                  six_cylinder_wheel;
  logic [1:0]            filter_level;

  logic [STAMP_BITS-1:0] last_edge_stamp,   last_edge_stamp_next;
  logic [STAMP_BITS-1:0] prior_edge_stamp,  prior_edge_stamp_next;
  logic                  last_valid,        last_valid_next;
  logic                  prior_valid,       prior_valid_next;
  logic [3:0]            physical_count,    physical_count_next;
  logic [2:0]            virtual_count,     virtual_count_next;
  logic [STAMP_BITS-1:0] noise_window,      noise_window_next;
  logic                  virtual_valid,     virtual_valid_next;
  logic [STAMP_BITS-1:0] cycle_stamp,       cycle_stamp_next;
  logic [STAMP_BITS-1:0] prior_cycle_stamp, prior_cycle_stamp_next;
  logic                  sync_flag,         sync_flag_next;
  logic [7:0]            loss_counter,      loss_counter_next;
  logic [31:0]           rev_counter,       rev_counter_next;
  logic                  parity_flag,       parity_flag_next;

  logic [STAMP_BITS-1:0] gap;
  logic [STAMP_BITS-1:0] prev_gap;
  logic [STAMP_BITS-1:0] window;
  logic                  acc;
  logic                  long_gap;
  logic                  lost;
  logic                  vevent;
  logic                  cstart;

  assign gap      = edge_time - last_edge_stamp;
  assign prev_gap = last_edge_stamp - prior_edge_stamp;
  assign acc      = (gap >= noise_window);
  assign long_gap = acc && ((last_valid && prior_valid) ? (prev_gap <= (gap >> 1))
                                                        : (gap >= NO_HISTORY_TARGET));

  always_comb begin
    case (filter_level_t'(filter_level))
      FILT_NONE:    window = '0;
      FILT_QUARTER: window = gap >> 2;
      FILT_HALF:    window = gap >> 1;
      FILT_THREEQ:  window = gap - (gap >> 2) - STAMP_BITS'(gap[1:0] != 2'd0);
      default:      window = '0;
    endcase
  end

  always_comb begin
    logic [3:0] pc;
    logic [2:0] vc;
    logic [2:0] limit;
    pc = physical_count;
    vc = virtual_count;
    limit = six_cylinder_wheel ? LIMIT_SIX : LIMIT_FOUR;

    last_edge_stamp_next   = last_edge_stamp;
    prior_edge_stamp_next  = prior_edge_stamp;
    last_valid_next        = last_valid;
    prior_valid_next       = prior_valid;
    noise_window_next      = noise_window;
    virtual_valid_next     = virtual_valid;
    cycle_stamp_next       = cycle_stamp;
    prior_cycle_stamp_next = prior_cycle_stamp;
    sync_flag_next         = sync_flag;
    loss_counter_next      = loss_counter;
    rev_counter_next       = rev_counter;
    parity_flag_next       = parity_flag;
    lost                   = 1'b0;
    vevent                 = 1'b0;
    cstart                 = 1'b0;

    if (acc) begin
      pc = pc + 4'd1;
      if (long_gap) begin
        pc = pc + 4'd2;
        if (pc != SYNC_TOOTH) begin
          // wrong tooth count at the gap: drop sync and restart counting
          lost              = 1'b1;
          sync_flag_next    = 1'b0;
          loss_counter_next = loss_counter + 8'd1;
          pc                = 4'd1;
          vc                = 3'd1;
        end
      end else begin
        noise_window_next = window;
      end

      prior_edge_stamp_next = last_edge_stamp;
      prior_valid_next      = last_valid;
      last_edge_stamp_next  = edge_time;
      last_valid_next       = 1'b1;

      if (pc == SYNC_TOOTH || !virtual_valid) begin
        vevent = 1'b1;
        vc     = vc + 3'd1;
        if (vc >= limit) begin
          cstart                 = 1'b1;
          prior_cycle_stamp_next = cycle_stamp;
          cycle_stamp_next       = edge_time;
          sync_flag_next         = 1'b1;
          rev_counter_next       = rev_counter + 32'd1;
          parity_flag_next       = ~parity_flag;
          vc                     = 3'd1;
        end
        pc                 = 4'd1;
        virtual_valid_next = 1'b1;
      end
    end

    physical_count_next = pc;
    virtual_count_next  = vc;
  end

  always_comb begin
    res.accepted            = acc;
    res.long_gap_seen       = long_gap;
    res.sync_lost_now       = lost;
    res.in_sync             = sync_flag_next;
    res.virtual_tooth       = virtual_count_next;
    res.virtual_tooth_event = vevent;
    res.cycle_start         = cstart;
    res.second_revolution   = parity_flag_next;
    res.sync_loss_total     = loss_counter_next;
    res.revolution_total    = rev_counter_next;
    res.cycle_period        = 32'(cycle_stamp_next - prior_cycle_stamp_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      six_cylinder_wheel  <= 1'b0;
      filter_level        <= FILT_QUARTER;
      last_edge_stamp     <= '0;
      prior_edge_stamp    <= '0;
      last_valid          <= 1'b0;
      prior_valid         <= 1'b0;
      physical_count      <= 4'd1;
      virtual_count       <= 3'd1;
      noise_window        <= STAMP_BITS'(INIT_FILTER_RESET);
      virtual_valid       <= 1'b0;
      cycle_stamp         <= '0;
      prior_cycle_stamp   <= '0;
      sync_flag           <= 1'b0;
      loss_counter        <= '0;
      rev_counter         <= '0;
      parity_flag         <= 1'b0;
    end else begin
      if (step) begin
        last_edge_stamp   <= last_edge_stamp_next;
        prior_edge_stamp  <= prior_edge_stamp_next;
        last_valid        <= last_valid_next;
        prior_valid       <= prior_valid_next;
        physical_count    <= physical_count_next;
        virtual_count     <= virtual_count_next;
        noise_window      <= noise_window_next;
        virtual_valid     <= virtual_valid_next;
        cycle_stamp       <= cycle_stamp_next;
        prior_cycle_stamp <= prior_cycle_stamp_next;
        sync_flag         <= sync_flag_next;
        loss_counter      <= loss_counter_next;
        rev_counter       <= rev_counter_next;
        parity_flag       <= parity_flag_next;
      end
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_WHEEL:       six_cylinder_wheel <= cfg_data[0];
          REG_FILTER:      filter_level       <= cfg_data[1:0];
          // reload the window at once
          REG_INIT_FILTER: noise_window       <= STAMP_BITS'(cfg_data);
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crank_wheel_gap_sync_decoder_unit.sv =====
// An accepted edge passes through the input register (edge_q) and then the result register (res_q);
// Throughput: one edge per cycle while out_ready keeps the result register free; cwg_core steps its state per edge.
// A new edge is taken while a finished result still waits in the result register.
// Reset (rst, synchronous): clears both stages, sync state and counters, and loads
// the configuration defaults (4-tooth virtual wheel, quarter filter, 50 us window).
`default_nettype none

module crank_wheel_gap_sync_decoder_unit
  import cwg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] edge_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             accepted,
  output logic             long_gap_seen,
  output logic             sync_lost_now,
  output logic             in_sync,
  output logic [2:0]       virtual_tooth,
  output logic             virtual_tooth_event,
  output logic             cycle_start,
  output logic             second_revolution,
  output logic [7:0]       sync_loss_total,
  output logic [31:0]      revolution_total,
  output logic [31:0]      cycle_period,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic                  in_full;
  logic [STAMP_BITS-1:0] edge_q;
  logic                  advance;
  result_t               res_comb;
  result_t               res_q;

  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;
  // hold configuration writes while an edge waits in the input stage
  assign cfg_ready = !in_full;

  cwg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .edge_time (edge_q),
    .res       (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers hold until the next transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      edge_q <= STAMP_BITS'(edge_time);
    end
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign accepted            = res_q.accepted;
  assign long_gap_seen       = res_q.long_gap_seen;
  assign sync_lost_now       = res_q.sync_lost_now;
  assign in_sync             = res_q.in_sync;
  assign virtual_tooth       = res_q.virtual_tooth;
  assign virtual_tooth_event = res_q.virtual_tooth_event;
  assign cycle_start         = res_q.cycle_start;
  assign second_revolution   = res_q.second_revolution;
  assign sync_loss_total     = res_q.sync_loss_total;
  assign revolution_total    = res_q.revolution_total;
  assign cycle_period        = res_q.cycle_period;

`ifndef SYNTHESIS
  a_reject_no_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> !long_gap_seen && !sync_lost_now &&
                               !virtual_tooth_event && !cycle_start)
    else $error("rejected edge carries an event");

  a_cycle_start_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && cycle_start |-> in_sync && virtual_tooth_event &&
                                 virtual_tooth == 3'd1)
    else $error("cycle start without sync on virtual tooth one");

  a_loss_drops_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && sync_lost_now |-> !in_sync && long_gap_seen)
    else $error("sync loss reported while still in sync");

  a_rev_count_step: assert property (@(posedge clk) disable iff (rst)
    advance && res_comb.cycle_start |=> revolution_total == $past(res_comb.revolution_total))
    else $error("revolution count not loaded with the cycle start");

  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(edge_q))
    else $error("input stage lost a pending edge");
`endif

endmodule

`default_nettype wire

// ===== tb/crank_wheel_gap_sync_decoder_unit_tb.sv =====
// Self-checking testbench for the crank wheel gap sync decoder unit.
`timescale 1ns / 100ps

module crank_wheel_gap_sync_decoder_unit_tb
  import cwg_pkg::*;
;

  // Index 3 decodes to no register and must be ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int unsigned MIN_PERIOD = 40;
  localparam int unsigned MAX_PERIOD = 40000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] edge_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        accepted;
  logic        long_gap_seen;
  logic        sync_lost_now;
  logic        in_sync;
  logic [2:0]  virtual_tooth;
  logic        virtual_tooth_event;
  logic        cycle_start;
  logic        second_revolution;
  logic [7:0]  sync_loss_total;
  logic [31:0] revolution_total;
  logic [31:0] cycle_period;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_WHEEL;
  logic [15:0] cfg_data = '0;

  crank_wheel_gap_sync_decoder_unit i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .edge_time           (edge_time),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .accepted            (accepted),
    .long_gap_seen       (long_gap_seen),
    .sync_lost_now       (sync_lost_now),
    .in_sync             (in_sync),
    .virtual_tooth       (virtual_tooth),
    .virtual_tooth_event (virtual_tooth_event),
    .cycle_start         (cycle_start),
    .second_revolution   (second_revolution),
    .sync_loss_total     (sync_loss_total),
    .revolution_total    (revolution_total),
    .cycle_period        (cycle_period),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("crank_wheel_gap_sync_decoder_unit verification failed");
    $finish;
  end

  // Decoder state mirror
  logic          wheel_six;
  filter_level_t filt_sel;
  logic [31:0]   last_stamp, prior_stamp, noise_win, cyc_stamp, prior_cyc_stamp, rev_cnt;
  logic          last_known, prior_known, tooth_known, synced, parity;
  logic [3:0]    phys_count;
  logic [2:0]    virt_count;
  logic [7:0]    loss_cnt;

  result_t     pending_decodes[$];
  int          mismatch_count = 0;
  bit          idle_en = 1'b1;
  int unsigned ready_hold = 0;

  // Wheel generator state
  logic [31:0] wheel_time;
  int unsigned wheel_slot;
  int unsigned tooth_period;

  function automatic void reset_decoder_model();
    wheel_six       = 1'b0;
    filt_sel        = FILT_QUARTER;
    last_stamp      = '0;
    prior_stamp     = '0;
    last_known      = 1'b0;
    prior_known     = 1'b0;
    tooth_known     = 1'b0;
    phys_count      = 4'd1;
    virt_count      = 3'd1;
    noise_win       = {16'b0, INIT_FILTER_RESET};
    cyc_stamp       = '0;
    prior_cyc_stamp = '0;
    synced          = 1'b0;
    parity          = 1'b0;
    loss_cnt        = '0;
    rev_cnt         = '0;
  endfunction

  function automatic result_t decode_edge(input logic [31:0] now);
    result_t     r;
    logic [31:0] gap;
    r   = '0;
    gap = now - last_stamp;
    if (gap >= noise_win) begin
      r.accepted = 1'b1;
      phys_count = phys_count + 4'd1;
      if (last_known && prior_known) begin
        r.long_gap_seen = ((last_stamp - prior_stamp) <= (gap >> 1));
      end else begin
        r.long_gap_seen = (gap >= NO_HISTORY_TARGET);
      end
      if (r.long_gap_seen) begin
        phys_count = phys_count + 4'd2;
        if (phys_count != SYNC_TOOTH) begin
          r.sync_lost_now = 1'b1;
          synced     = 1'b0;
          loss_cnt   = loss_cnt + 8'd1;
          phys_count = 4'd1;
          virt_count = 3'd1;
        end
      end else begin
        case (filt_sel)
          FILT_NONE:    noise_win = '0;
          FILT_QUARTER: noise_win = gap >> 2;
          FILT_HALF:    noise_win = gap >> 1;
          FILT_THREEQ:  noise_win = gap - (gap >> 2) - {31'b0, gap[1:0] != 2'b00};
          default:      noise_win = '0;
        endcase
      end
      prior_stamp = last_stamp;
      prior_known = last_known;
      last_stamp  = now;
      last_known  = 1'b1;
      if (phys_count == SYNC_TOOTH || !tooth_known) begin
        r.virtual_tooth_event = 1'b1;
        virt_count = virt_count + 3'd1;
        if (virt_count >= (wheel_six ? LIMIT_SIX : LIMIT_FOUR)) begin
          r.cycle_start   = 1'b1;
          prior_cyc_stamp = cyc_stamp;
          cyc_stamp       = now;
          synced          = 1'b1;
          rev_cnt         = rev_cnt + 32'd1;
          parity          = ~parity;
          virt_count      = 3'd1;
        end
        phys_count  = 4'd1;
        tooth_known = 1'b1;
      end
    end
    r.in_sync           = synced;
    r.virtual_tooth     = virt_count;
    r.second_revolution = parity;
    r.sync_loss_total   = loss_cnt;
    r.revolution_total  = rev_cnt;
    r.cycle_period      = cyc_stamp - prior_cyc_stamp;
    return r;
  endfunction

  // Result side: random stall bursts on out_ready
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) out_ready <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(1, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t: result transaction with no expected decode", $time);
        mismatch_count++;
      end else begin
        want = pending_decodes.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(accepted));
        check_field("long_gap_seen", 32'(want.long_gap_seen), 32'(long_gap_seen));
        check_field("sync_lost_now", 32'(want.sync_lost_now), 32'(sync_lost_now));
        check_field("in_sync", 32'(want.in_sync), 32'(in_sync));
        check_field("virtual_tooth", 32'(want.virtual_tooth), 32'(virtual_tooth));
        check_field("virtual_tooth_event", 32'(want.virtual_tooth_event),
                    32'(virtual_tooth_event));
        check_field("cycle_start", 32'(want.cycle_start), 32'(cycle_start));
        check_field("second_revolution", 32'(want.second_revolution),
                    32'(second_revolution));
        check_field("sync_loss_total", 32'(want.sync_loss_total), 32'(sync_loss_total));
        check_field("revolution_total", want.revolution_total, revolution_total);
        check_field("cycle_period", want.cycle_period, cycle_period);
      end
    end
  end

  task automatic send_edge(input logic [31:0] stamp);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    edge_time <= stamp;
    do @(posedge clk); while (!in_ready);
    pending_decodes.push_back(decode_edge(stamp));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WHEEL:       wheel_six = val[0];
      REG_FILTER:      filt_sel  = filter_level_t'(val[1:0]);
      REG_INIT_FILTER: noise_win = {16'b0, val};
      default: ;
    endcase
  endtask

  // Drive a toothed wheel of groups*11 slots with the last two slots missing.
  task automatic run_wheel(input int unsigned n_edges, input int unsigned groups,
                           input int unsigned glitch_pct, input int unsigned drop_pct);
    int unsigned slots, gap_slots, advances;
    slots = 11 * groups;
    wheel_slot = wheel_slot % slots;
    for (int i = 0; i < n_edges; i++) begin
      gap_slots = 0;
      advances  = ($urandom_range(0, 99) < drop_pct) ? 2 : 1;
      repeat (advances) begin
        wheel_slot = (wheel_slot + 1) % slots;
        gap_slots++;
        while (wheel_slot >= slots - 2) begin
          wheel_slot = (wheel_slot + 1) % slots;
          gap_slots++;
        end
      end
      if ($urandom_range(0, 99) < glitch_pct)
        send_edge(wheel_time + $urandom_range(1, tooth_period / 8 + 1));
      // drift the crank speed a little each tooth
      tooth_period = tooth_period + $urandom_range(0, tooth_period / 16) - tooth_period / 32;
      if (tooth_period < MIN_PERIOD) tooth_period = MIN_PERIOD;
      if (tooth_period > MAX_PERIOD) tooth_period = MAX_PERIOD;
      wheel_time = wheel_time + gap_slots * tooth_period;
      send_edge(wheel_time);
    end
  endtask

  task automatic new_crank_speed();
    wheel_time   = $urandom;
    wheel_slot   = $urandom_range(0, 65);
    tooth_period = $urandom_range(MIN_PERIOD, 20000);
  endtask

  task automatic test_directed_edges();
    send_edge(32'h0000_0000);              // rejected, gap zero from reset stamp
    send_edge(32'd49);                     // just under the reset window
    send_edge(32'd50);                     // at the window: first accepted edge
    send_edge(32'd50 + NO_HISTORY_TARGET); // long gap with no history
    send_edge(32'd1050 + NO_HISTORY_TARGET);
    send_edge(32'hFFFF_FFFF);
    send_edge(32'h0000_0009);              // wrapped, inside window
    send_edge(32'h0000_0200);
    send_edge(32'h8000_01FF);
    send_edge(32'h8000_01FD);              // gap exactly twice the previous one
    send_edge(32'h8000_01FA);              // gap one short of the previous one
    send_edge(32'h8000_0200);
  endtask

  task automatic test_four_tooth_sync();
    new_crank_speed();
    run_wheel(100, 4, 0, 0);
    wait_drained();
    run_wheel(100, 4, 5, 1);
  endtask

  task automatic test_filter_and_wheel_settings();
    logic [15:0] init_pick;
    for (int w = 0; w < 2; w++) begin
      for (int f = FILT_NONE; f <= FILT_THREEQ; f++) begin
        case ($urandom_range(0, 2))
          0:       init_pick = 16'h0000;
          1:       init_pick = 16'hFFFF;
          default: init_pick = 16'($urandom);
        endcase
        write_reg(REG_WHEEL, {15'($urandom_range(0, 16'h7FFF)), w[0]});
        write_reg(REG_FILTER, {14'($urandom_range(0, 16'h3FFF)), f[1:0]});
        write_reg(REG_INIT_FILTER, init_pick);
        write_reg(REG_SPARE, 16'($urandom));
        new_crank_speed();
        run_wheel(40, w ? 6 : 4, 6, 2);
      end
    end
  endtask

  // Switching the wheel size leaves the virtual tooth past the new limit.
  task automatic test_wheel_switch();
    write_reg(REG_FILTER, 16'(FILT_QUARTER));
    write_reg(REG_WHEEL, 16'd1);
    new_crank_speed();
    run_wheel(80, 6, 0, 0);
    for (int k = 0; k < 6; k++) begin
      write_reg(REG_WHEEL, 16'd0);
      run_wheel($urandom_range(5, 30), 4, 0, 0);
      write_reg(REG_WHEEL, 16'd1);
      run_wheel($urandom_range(5, 40), 6, 0, 0);
    end
  endtask

  // Alternate gaps of T and 2T to 2T+3 so long gaps keep losing sync and wrap the loss count.
  task automatic test_sync_loss_wrap();
    int unsigned t;
    write_reg(REG_WHEEL, 16'd0);
    new_crank_speed();
    for (int i = 0; i < 262; i++) begin
      t = $urandom_range(100, 5000);
      wheel_time = wheel_time + t;
      send_edge(wheel_time);
      wheel_time = wheel_time + 2 * t + $urandom_range(0, 3);
      send_edge(wheel_time);
    end
  endtask

  task automatic test_random_edges();
    write_reg(REG_FILTER, 16'($urandom_range(0, 3)));
    for (int i = 0; i < 160; i++) begin
      case ($urandom_range(0, 3))
        0:       wheel_time = $urandom;
        1:       wheel_time = wheel_time + $urandom_range(0, 255);
        2:       wheel_time = wheel_time + $urandom_range(0, 1 << 20);
        default: wheel_time = wheel_time + $urandom_range(1000, 3000);
      endcase
      send_edge(wheel_time);
    end
  endtask

  task automatic test_steady_run();
    idle_en = 1'b0;
    write_reg(REG_FILTER, 16'(FILT_HALF));
    write_reg(REG_WHEEL, 16'd0);
    new_crank_speed();
    run_wheel(160, 4, 3, 0);
  endtask

  initial begin
    reset_decoder_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_four_tooth_sync();
    test_filter_and_wheel_settings();
    test_wheel_switch();
    test_sync_loss_wrap();
    test_random_edges();
    test_steady_run();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("crank_wheel_gap_sync_decoder_unit verification clean");
    end else begin
      $display("crank_wheel_gap_sync_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
